[rtl/core/lrupr_pkg.sv]
// shared constants and control types for the lru page replacement table
`default_nettype none

package lrupr_pkg;

	// default geometry
	localparam int FRAMES_DEF    = 4;
	localparam int PAGE_BITS_DEF = 16;

	// fixed field widths on the stream ports
	localparam int PAGE_W   = 16;
	localparam int IDX_W    = 4;
	localparam int FAULT_W  = 32;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_FIELD_W = 1 + IDX_W + 1 + PAGE_W + FAULT_W;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

	// controller to datapath commands
	typedef struct packed {
		logic load;    // capture the incoming request
		logic lookup;  // compare the table and pick the frame
		logic commit;  // update the table and load the result register
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic out_busy; // result register full and not taken this cycle
	} sts_t;

endpackage

`default_nettype wire

[rtl/core/lrupr_ctrl.sv]
// sequencer for one page request: capture, lookup, commit
`default_nettype none

module lrupr_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	output lrupr_pkg::cmd_t       cmd,
	input  wire lrupr_pkg::sts_t  sts
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_COMMIT
	} state_t;

	state_t state_q;
	logic   ready_q;

	// state and registered ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid && ready_q) begin
						state_q <= ST_LOOKUP;
						ready_q <= 1'b0;
					end
				end
				ST_LOOKUP: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (!sts.out_busy) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign s_tready = ready_q;

	// commands to the datapath
	always_comb begin
		cmd.load   = s_tvalid && ready_q;
		cmd.lookup = (state_q == ST_LOOKUP);
		cmd.commit = (state_q == ST_COMMIT) && !sts.out_busy;
	end

endmodule

`default_nettype wire

[rtl/core/lrupr_dp.sv]
// frame table, recency ranks, fault counter and result register
`default_nettype none

module lrupr_dp #(
	parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire lrupr_pkg::cmd_t                     cmd,
	output lrupr_pkg::sts_t                          sts,
	input  wire logic [lrupr_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [lrupr_pkg::OUT_TDATA_W-1:0]        m_tdata
);

	localparam int IW     = $clog2(FRAMES);
	localparam int RANK_W = $clog2(FRAMES);
	localparam int KEEP   = (PAGE_BITS < lrupr_pkg::PAGE_W) ? PAGE_BITS : lrupr_pkg::PAGE_W;

	// table state
	logic [PAGE_BITS-1:0] page_q [FRAMES];
	logic [FRAMES-1:0]    valid_q;
	logic [RANK_W-1:0]    rank_q [FRAMES];
	logic [lrupr_pkg::FAULT_W-1:0] faults_q;

	// request key
	logic [PAGE_BITS-1:0] key_q;

	// lookup results
	logic                 hit_c, empty_c;
	logic [IW-1:0]        hit_idx_c, empty_idx_c, lru_idx_c, slot_c;
	logic                 hit_s1, evv_s1, old_valid_s1;
	logic [IW-1:0]        slot_s1;
	logic [RANK_W-1:0]    old_rank_s1;
	logic [lrupr_pkg::PAGE_W-1:0] evp_s1;

	// result register
	logic                          out_valid_q;
	logic                          hit_q, evv_q;
	logic [lrupr_pkg::IDX_W-1:0]   idx_q;
	logic [lrupr_pkg::PAGE_W-1:0]  evp_q;
	logic [lrupr_pkg::FAULT_W-1:0] fc_q;
	logic [lrupr_pkg::FAULT_W-1:0] faults_nx;

	// capture the page, upper bits beyond the stored width dropped
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= PAGE_BITS'(s_tdata[KEEP-1:0]);
		end
	end

	// parallel compare; lowest index wins every search
	always_comb begin
		hit_c       = 1'b0;
		empty_c     = 1'b0;
		hit_idx_c   = '0;
		empty_idx_c = '0;
		lru_idx_c   = '0;
		for (int k = FRAMES - 1; k >= 0; k--) begin
			if (valid_q[k] && (page_q[k] == key_q)) begin
				hit_c     = 1'b1;
				hit_idx_c = IW'(k);
			end
			if (!valid_q[k]) begin
				empty_c     = 1'b1;
				empty_idx_c = IW'(k);
			end
			if (rank_q[k] == RANK_W'(FRAMES - 1)) begin
				lru_idx_c = IW'(k);
			end
		end
	end

	// frame choice: hit frame, else first empty, else the oldest
	always_comb begin
		priority if (hit_c) begin
			slot_c = hit_idx_c;
		end else if (empty_c) begin
			slot_c = empty_idx_c;
		end else begin
			slot_c = lru_idx_c;
		end
	end

	// lookup stage register
	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			hit_s1       <= hit_c;
			slot_s1      <= slot_c;
			evv_s1       <= !hit_c && !empty_c;
			evp_s1       <= (!hit_c && !empty_c) ?
				lrupr_pkg::PAGE_W'(page_q[slot_c]) : '0;
			old_valid_s1 <= valid_q[slot_c];
			old_rank_s1  <= rank_q[slot_c];
		end
	end

	// saturating fault count after this request
	always_comb begin
		faults_nx = faults_q;
		if (!hit_s1 && (faults_q != '1)) begin
			faults_nx = faults_q + 1'b1;
		end
	end

	// page store, written on a miss
	always_ff @(posedge clk) begin
		if (cmd.commit && !hit_s1) begin
			page_q[slot_s1] <= key_q;
		end
	end

	// valid bits, ranks and counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			faults_q <= '0;
			for (int k = 0; k < FRAMES; k++) begin
				rank_q[k] <= '0;
			end
		end else if (cmd.commit) begin
			faults_q <= faults_nx;
			for (int k = 0; k < FRAMES; k++) begin
				if (IW'(k) == slot_s1) begin
					rank_q[k]  <= '0;
					valid_q[k] <= 1'b1;
				end else if (valid_q[k] && (!old_valid_s1 || (rank_q[k] < old_rank_s1))) begin
					rank_q[k] <= rank_q[k] + 1'b1;
				end
			end
		end
	end

	// result register flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hit_q <= hit_s1;
			idx_q <= lrupr_pkg::IDX_W'(slot_s1);
			evv_q <= evv_s1;
			evp_q <= evp_s1;
			fc_q  <= faults_nx;
		end
	end

	assign m_tvalid     = out_valid_q;
	assign m_tdata      = {{lrupr_pkg::OUT_PAD_W{1'b0}}, fc_q, evp_q, evv_q, idx_q, hit_q};
	assign sts.out_busy = out_valid_q && !m_tready;

endmodule

`default_nettype wire

[rtl/core/lru_page_replacement.sv]
// lru page replacement table: top level with controller and datapath
//
// Usage:
//   s_* channel carries one page reference per request; m_* channel returns
//   one result per request: hit flag, frame now holding the page, whether a
//   resident page was replaced and which, and the saturating fault count.
//   A hit makes the frame most recent; a miss fills the lowest empty frame,
//   or replaces the least recently used one when the table is full.
// Timing:
//   A request is captured at its acceptance edge, compared against all frames
//   in the next cycle and committed once the result register is free; the
//   result register is loaded at the commit, and a new request is taken only
//   after the previous one is committed. The controller runs the three steps
//   (capture, lookup, commit) in sequence.
// Reset:
//   arst_n clears all valid bits, ranks and the fault counter; the table
//   starts empty and s_tready is high right after reset.
// Stall:
//   A result waits in the output register while m_tready is low; the next
//   request is still accepted and looked up, and its commit waits until the
//   register is free.
`default_nettype none

module lru_page_replacement #(
	parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// page
	input  wire logic [lrupr_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// hit, frame_index, evicted_valid, evicted_page, fault_count
	output logic [lrupr_pkg::OUT_TDATA_W-1:0]         m_tdata
);

	lrupr_pkg::cmd_t cmd;
	lrupr_pkg::sts_t sts;

	// sequencer
	lrupr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// table and result register
	lrupr_dp #(
		.FRAMES    (FRAMES),
		.PAGE_BITS (PAGE_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// one request in flight at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted while another is in flight");

	// a commit never overwrites a result still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !sts.out_busy)
		else $error("commit while result register is busy");

	// a commit always presents a result in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> m_tvalid)
		else $error("committed result not presented");

endmodule

`default_nettype wire

[verif/lru_ref_checker.sv]
// checker for the lru page replacement table: tracks the frame table and compares every result
`timescale 1ns / 100ps

module lru_ref_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	input  logic                                 s_tready,
	// page
	input  logic [lrupr_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  logic                                 m_tvalid,
	input  logic                                 m_tready,
	// hit, frame_index, evicted_valid, evicted_page, fault_count
	input  logic [lrupr_pkg::OUT_TDATA_W-1:0]    m_tdata,
	output int                                   mismatches,
	output int                                   outstanding
);

	import lrupr_pkg::*;

	localparam int FRAMES    = FRAMES_DEF;
	localparam int PAGE_BITS = PAGE_BITS_DEF;
	localparam int AGE_W     = (FRAMES > 2) ? $clog2(FRAMES) : 1;
	localparam logic [PAGE_W-1:0] PAGE_MASK =
		(PAGE_BITS >= PAGE_W) ? {PAGE_W{1'b1}} : PAGE_W'((1 << PAGE_BITS) - 1);

	// result layout on m_tdata, highest field first
	typedef struct packed {
		logic [OUT_PAD_W-1:0] pad;
		logic [FAULT_W-1:0]   faults;
		logic [PAGE_W-1:0]    ev_page;
		logic                 ev_valid;
		logic [IDX_W-1:0]     frame;
		logic                 hit;
	} lru_result_t;

	// shadow of the frame table
	logic [PAGE_W-1:0]  tbl_page  [FRAMES];
	logic               tbl_valid [FRAMES];
	logic [AGE_W-1:0]   tbl_age   [FRAMES];
	logic [FAULT_W-1:0] fault_total;

	lru_result_t pending_results[$];

	// look up one page reference and update the shadow table
	function automatic lru_result_t predict_reference(input logic [PAGE_W-1:0] raw);
		lru_result_t r;
		logic [PAGE_W-1:0] pg;
		int slot;
		int best;
		int old_age;
		r = '0;
		slot = -1;
		pg = raw & PAGE_MASK;
		for (int j = 0; j < FRAMES; j++)
			if (slot < 0 && tbl_valid[j] && tbl_page[j] == pg)
				slot = j;
		r.hit = (slot >= 0);
		if (!r.hit) begin
			// lowest empty frame first
			for (int j = 0; j < FRAMES; j++)
				if (slot < 0 && !tbl_valid[j])
					slot = j;
			// table full: replace the oldest frame
			if (slot < 0) begin
				best = 0;
				slot = 0;
				for (int j = 0; j < FRAMES; j++)
					if (int'(tbl_age[j]) > best) begin
						best = int'(tbl_age[j]);
						slot = j;
					end
				r.ev_valid = 1'b1;
				r.ev_page  = tbl_page[slot];
			end
			tbl_page[slot] = pg;
			if (fault_total != {FAULT_W{1'b1}})
				fault_total = fault_total + 1'b1;
		end
		// frame becomes most recent, younger valid frames age by one
		old_age = tbl_valid[slot] ? int'(tbl_age[slot]) : FRAMES;
		for (int k = 0; k < FRAMES; k++)
			if (k != slot && tbl_valid[k] && int'(tbl_age[k]) < old_age)
				tbl_age[k] = tbl_age[k] + 1'b1;
		tbl_age[slot]   = '0;
		tbl_valid[slot] = 1'b1;
		r.frame  = IDX_W'(slot);
		r.faults = fault_total;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// predict on each request, compare on each result
	always @(posedge clk or negedge arst_n) begin
		lru_result_t want;
		lru_result_t got;
		if (!arst_n) begin
			for (int j = 0; j < FRAMES; j++) begin
				tbl_page[j]  = '0;
				tbl_valid[j] = 1'b0;
				tbl_age[j]   = '0;
			end
			fault_total = '0;
			pending_results.delete();
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = lru_result_t'(m_tdata);
				if (pending_results.size() == 0) begin
					$display("%0t: result with none expected, expected none, actual %0h",
						$time, m_tdata);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					check_field("hit", 64'(want.hit), 64'(got.hit));
					check_field("frame_index", 64'(want.frame), 64'(got.frame));
					check_field("evicted_valid", 64'(want.ev_valid), 64'(got.ev_valid));
					check_field("evicted_page", 64'(want.ev_page), 64'(got.ev_page));
					check_field("fault_count", 64'(want.faults), 64'(got.faults));
				end
			end
			if (s_tvalid && s_tready)
				pending_results.push_back(predict_reference(s_tdata[PAGE_W-1:0]));
			outstanding <= pending_results.size();
		end
	end

	initial mismatches = 0;

endmodule

[verif/tb.sv]
// testbench top for the lru page replacement table: clock, reset, page stream and verdict
`timescale 1ns / 100ps

module tb;

	import lrupr_pkg::*;

	localparam int RANDOM_REFS = 1900;
	localparam int IDLE_LIMIT  = 5000;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	int                     mismatches;
	int                     outstanding;
	int                     idle_cycles = 0;
	int                     results_seen = 0;

	always #5 clk = ~clk;

	lru_page_replacement uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	lru_ref_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		else if (roll < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(5, 30);
	endfunction

	// offer one page reference and wait for it to be taken
	task automatic send_page(input logic [IN_TDATA_W-1:0] pg, input bit no_gap);
		int gap;
		gap = no_gap ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pg;
		do @(posedge clk); while (!s_tready);
	endtask

	// receiver: random stalls, stall-free stretches and two long hold-offs
	initial begin
		int stall;
		int hold;
		bit held_early;
		bit held_late;
		stall = 0;
		hold = 0;
		held_early = 1'b0;
		held_late = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				results_seen++;
			if (!held_early && results_seen >= 300) begin
				held_early = 1'b1;
				hold = 120;
			end
			if (!held_late && results_seen >= 1100) begin
				held_late = 1'b1;
				hold = 60;
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else if (((results_seen / 150) % 3) == 2) begin
				m_tready <= 1'b1;
			end else if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else if ($urandom_range(0, 99) < 25) begin
				stall = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
					: $urandom_range(0, 2);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no request or result moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[lru_page_replacement] ERROR");
				$finish;
			end
		end
	end

	// stimulus and verdict
	initial begin
		logic [IN_TDATA_W-1:0] pool[8];
		int pool_size;
		logic [IN_TDATA_W-1:0] pg;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the empty table, hits on oldest and newest, then replacements
		send_page(16'h0000, 1'b0);
		send_page(16'hFFFF, 1'b0);
		send_page(16'h5555, 1'b1);
		send_page(16'hAAAA, 1'b1);
		send_page(16'h0000, 1'b0);
		send_page(16'h0000, 1'b1);
		send_page(16'hAAAA, 1'b0);
		send_page(16'h1234, 1'b1);
		send_page(16'hFFFF, 1'b1);
		send_page(16'h5555, 1'b0);
		send_page(16'h0001, 1'b1);
		send_page(16'h8000, 1'b0);
		send_page(16'h0001, 1'b1);
		send_page(16'hFFFF, 1'b0);
		send_page(16'h7FFE, 1'b1);
		send_page(16'h8000, 1'b1);

		// working sets of random pages with some stray references
		pool_size = 5;
		for (int i = 0; i < 8; i++)
			pool[i] = IN_TDATA_W'($urandom_range(0, 16'hFFFF));
		for (int n = 0; n < RANDOM_REFS; n++) begin
			if (n % 100 == 0) begin
				pool_size = $urandom_range(2, 8);
				for (int i = 0; i < 8; i++)
					if ($urandom_range(0, 1))
						pool[i] = IN_TDATA_W'($urandom_range(0, 16'hFFFF));
			end
			if ($urandom_range(0, 99) < 85)
				pg = pool[$urandom_range(0, pool_size - 1)];
			else
				pg = IN_TDATA_W'($urandom_range(0, 16'hFFFF));
			send_page(pg, ((n / 128) % 4) == 3);
		end
		s_tvalid <= 1'b0;

		// drain outstanding results once the last request is counted
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("[lru_page_replacement] OK");
		else
			$display("[lru_page_replacement] ERROR");
		$finish;
	end

endmodule
